FILE: rtl/core/blsp_pkg.sv
// ----------------------------------------------------------------------------
// blsp_pkg
// Types and constants shared by the Bresenham line stepper.
// ----------------------------------------------------------------------------
package blsp_pkg;

  localparam int CoordBits = 12;
  localparam int ErrBits   = CoordBits + 2;
  localparam int CntBits   = CoordBits + 1;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                        mode;
    logic signed [CoordBits-1:0]  x_start;
    logic signed [CoordBits-1:0]  y_start;
    logic signed [CoordBits-1:0]  x_end;
    logic signed [CoordBits-1:0]  y_end;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordBits-1:0]  point_x;
    logic signed [CoordBits-1:0]  point_y;
    logic                         last;
  } out_item_t;

endpackage

FILE: rtl/core/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Bresenham line rasterizer for all octants, one point per advance request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): a load request (mode 0)
//   sets up a new line from its two endpoints and returns nothing; it
//   replaces any line in progress. Each advance request (mode 1) returns
//   the next point of the line, with last set on the final point. Advance
//   requests with no line in progress return nothing.
//   Result channel (out_valid / out_stall / out_data): one point per
//   advance request that finds a line in progress, in request order.
//   Each result is registered in the output stage. One request is
//   accepted every cycle while in_stall is low; the stepping logic closes
//   its loop combinationally (an add and a conditional subtract on the
//   error term, one add on each coordinate).
//   A two-entry output stage (result register plus skid register) lets a
//   request be accepted while a result waits; in_stall rises only when
//   both entries are full, and is a registered signal.
//   Reset clears all line state: no line is active and the output is empty.
// ----------------------------------------------------------------------------
module bresenham_line_stepper (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  blsp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output blsp_pkg::out_item_t  out_data
);

  localparam int N  = blsp_pkg::CoordBits;
  localparam int EB = blsp_pkg::ErrBits;
  localparam int CB = blsp_pkg::CntBits;

  // line state
  logic signed [N-1:0]  cur_x_r, cur_x_nxt;
  logic signed [N-1:0]  cur_y_r, cur_y_nxt;
  logic signed [EB-1:0] err_r, err_nxt;
  logic [N-1:0]         major_r, major_nxt;
  logic [N-1:0]         minor_r, minor_nxt;
  logic signed [1:0]    step_x_r, step_x_nxt;
  logic signed [1:0]    step_y_r, step_y_nxt;
  logic                 steep_r, steep_nxt;
  logic [CB-1:0]        left_r, left_nxt;
  logic                 active_r, active_nxt;

  // output stage
  logic                 out_valid_r;
  blsp_pkg::out_item_t  out_data_r;
  logic                 skid_valid_r;
  blsp_pkg::out_item_t  skid_data_r;

  logic                 accept;
  logic                 res_valid;
  blsp_pkg::out_item_t  res;
  logic                 out_take;

  // load path
  logic signed [N:0]    dx, dy;
  logic [N:0]           adx_w, ady_w;
  logic [N-1:0]         adx, ady;
  logic                 ld_steep;
  logic [N-1:0]         ld_major, ld_minor;

  // advance path
  logic                 minor_step;
  logic signed [EB:0]   err_wide;
  logic signed [N-1:0]  inc_x, inc_y;
  logic                 move_x, move_y;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign res_valid = accept && (in_data.mode == blsp_pkg::MODE_ADVANCE) && active_r;
  assign res.point_x = cur_x_r;
  assign res.point_y = cur_y_r;
  assign res.last    = (left_r == CB'(1));

  always_comb begin
    dx    = (N+1)'(in_data.x_end) - (N+1)'(in_data.x_start);
    dy    = (N+1)'(in_data.y_end) - (N+1)'(in_data.y_start);
    adx_w = dx[N] ? (N+1)'(-dx) : dx;
    ady_w = dy[N] ? (N+1)'(-dy) : dy;
    adx   = adx_w[N-1:0];
    ady   = ady_w[N-1:0];
    ld_steep = ady > adx;
    ld_major = ld_steep ? ady : adx;
    ld_minor = ld_steep ? adx : ady;
  end

  always_comb begin
    minor_step = !err_r[EB-1] && (major_r != '0);
    err_wide   = (EB+1)'(err_r) + $signed({2'b00, minor_r, 1'b0});
    if (minor_step) begin
      err_wide = err_wide - $signed({2'b00, major_r, 1'b0});
    end
    inc_x  = N'(step_x_r);
    inc_y  = N'(step_y_r);
    move_x = steep_r ? minor_step : 1'b1;
    move_y = steep_r ? 1'b1 : minor_step;
  end

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    step_x_nxt = step_x_r;
    step_y_nxt = step_y_r;
    steep_nxt  = steep_r;
    left_nxt   = left_r;
    active_nxt = active_r;
    if (accept && in_data.mode == blsp_pkg::MODE_LOAD) begin
      cur_x_nxt  = in_data.x_start;
      cur_y_nxt  = in_data.y_start;
      step_x_nxt = (dx == '0) ? 2'sd0 : (dx[N] ? -2'sd1 : 2'sd1);
      step_y_nxt = (dy == '0) ? 2'sd0 : (dy[N] ? -2'sd1 : 2'sd1);
      steep_nxt  = ld_steep;
      major_nxt  = ld_major;
      minor_nxt  = ld_minor;
      err_nxt    = $signed({1'b0, ld_minor, 1'b0}) - $signed({2'b00, ld_major});
      left_nxt   = {1'b0, ld_major} + CB'(1);
      active_nxt = 1'b1;
    end else if (res_valid) begin
      cur_x_nxt  = move_x ? cur_x_r + inc_x : cur_x_r;
      cur_y_nxt  = move_y ? cur_y_r + inc_y : cur_y_r;
      err_nxt    = err_wide[EB-1:0];
      left_nxt   = left_r - CB'(1);
      active_nxt = (left_r != CB'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      err_r    <= '0;
      major_r  <= '0;
      minor_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      steep_r  <= 1'b0;
      left_r   <= '0;
      active_r <= 1'b0;
    end else begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      err_r    <= err_nxt;
      major_r  <= major_nxt;
      minor_r  <= minor_nxt;
      step_x_r <= step_x_nxt;
      step_y_r <= step_y_nxt;
      steep_r  <= steep_nxt;
      left_r   <= left_nxt;
      active_r <= active_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (res_valid) begin
      skid_data_r <= res;
    end
  end

endmodule
